// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each use names the label, the property and the message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define NQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define NQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/nq_pkg.sv
// ----------------------------------------------------------------------------
// nq_pkg
// Types and constants shared by the queen search cells, the row sequencer
// and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package nq_pkg;

	localparam int MAX_ROWS   = 8;
	localparam int ROW_W      = $clog2(MAX_ROWS + 1);
	localparam int COL_IDX_W  = $clog2(MAX_ROWS);
	localparam int SIZE_W     = 4;
	localparam int COUNT_W    = 7;
	localparam int PLACE_BITS = 3;
	localparam int PLACE_W    = 24;

	localparam logic [SIZE_W-1:0] BOARD_RESET = SIZE_W'(8);

	typedef logic [ROW_W-1:0]    col_t;
	typedef logic [MAX_ROWS-1:0] mask_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_NEXT,
		OP_PLACE
	} cell_op_t;

	// occupancy seen by the next row down
	typedef struct packed {
		mask_t cols;
		mask_t down;
		mask_t up;
	} occ_t;

	typedef struct packed {
		col_t choice;
		logic free;
	} cell_stat_t;

endpackage

`default_nettype wire

// File: rtl/n_queens_solution_enumerator_core.sv
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_core
// Resumable N-queens search: a chain of row cells driven by a row sequencer
// returns the next solution, or exhaustion, for each request item.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Handshake
// -------   ---------------------------------------   --------------------
// in        restart                                   in_valid / in_ready
// out       found exhausted placement solution_number out_valid / out_ready
// cfg       cfg_wdata (board size)                    cfg_we, no stall
//
// One search step per cycle (try a column, back up a row or lift the last
// queen); the last step of an item loads the result.
// Reset leaves a cleared search on an 8x8 board; no clearing pass.
// A new item is taken only between searches and not during a size write; a
// waiting result holds the search on its last step until the output frees.
`default_nettype none

module n_queens_solution_enumerator_core (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [nq_pkg::SIZE_W-1:0]         cfg_wdata,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               restart,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              found,
	output logic                              exhausted,
	output logic [nq_pkg::PLACE_W-1:0]        placement,
	output logic [nq_pkg::COUNT_W-1:0]        solution_number
);

	nq_pkg::cell_stat_t stat    [nq_pkg::MAX_ROWS];
	nq_pkg::cell_op_t   ops     [nq_pkg::MAX_ROWS];
	nq_pkg::occ_t       occ_out [nq_pkg::MAX_ROWS];

	for (genvar r = 0; r < nq_pkg::MAX_ROWS; r++) begin : g_row
		nq_pkg::occ_t occ_in;
		if (r == 0) begin : g_top
			assign occ_in = '0;
		end else begin : g_mid
			assign occ_in = occ_out[r-1];
		end
		nq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (ops[r]),
			.occ_in  (occ_in),
			.occ_out (occ_out[r]),
			.stat    (stat[r])
		);
	end

	nq_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.exhausted       (exhausted),
		.placement       (placement),
		.solution_number (solution_number),
		.stat            (stat),
		.ops             (ops)
	);

endmodule

`default_nettype wire

// File: rtl/nq_cell.sv
// ----------------------------------------------------------------------------
// nq_cell
// One board row: holds the queen column tried or placed in this row and the
// column and diagonal occupancy that it hands to the row below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nq_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  nq_pkg::cell_op_t    op,
	input  nq_pkg::occ_t        occ_in,
	output nq_pkg::occ_t        occ_out,
	output nq_pkg::cell_stat_t  stat
);

	nq_pkg::col_t                         choice_q;
	nq_pkg::occ_t                         occ_q;
	logic [nq_pkg::COL_IDX_W-1:0]         idx;
	nq_pkg::mask_t                        onehot;
	nq_pkg::mask_t                        taken;

	assign idx    = choice_q[nq_pkg::COL_IDX_W-1:0];
	assign onehot = nq_pkg::mask_t'(1) << idx;
	assign taken  = occ_in.cols | occ_in.down | occ_in.up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			choice_q <= '0;
		end else begin
			unique case (op)
				nq_pkg::OP_CLEAR: choice_q <= '0;
				nq_pkg::OP_NEXT:  choice_q <= choice_q + nq_pkg::col_t'(1);
				default:          choice_q <= choice_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == nq_pkg::OP_PLACE) begin
			occ_q.cols <= occ_in.cols | onehot;
			occ_q.down <= (occ_in.down | onehot) << 1;
			occ_q.up   <= (occ_in.up | onehot) >> 1;
		end
	end

	assign occ_out     = occ_q;
	assign stat.choice = choice_q;
	assign stat.free   = (choice_q < nq_pkg::col_t'(nq_pkg::MAX_ROWS)) && !taken[idx];

	`NQ_ASSERT_ALWAYS(a_choice_range, choice_q <= nq_pkg::col_t'(nq_pkg::MAX_ROWS),
		"column choice beyond board")
	`NQ_ASSERT(a_place_free, op == nq_pkg::OP_PLACE |-> stat.free,
		"queen placed on an attacked square")
	`NQ_ASSERT(a_next_bound, op == nq_pkg::OP_NEXT |-> choice_q < nq_pkg::col_t'(nq_pkg::MAX_ROWS),
		"column advanced past the last column")

endmodule

`default_nettype wire

// File: rtl/nq_ctrl.sv
// ----------------------------------------------------------------------------
// nq_ctrl
// Row sequencer: moves the row pointer up and down the cells, one try per
// cycle unless a result waits; holds board size, solution count, result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nq_ctrl (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [nq_pkg::SIZE_W-1:0]         cfg_wdata,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire                               restart,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic                              found,
	output logic                              exhausted,
	output logic [nq_pkg::PLACE_W-1:0]        placement,
	output logic [nq_pkg::COUNT_W-1:0]        solution_number,
	input  nq_pkg::cell_stat_t                stat [nq_pkg::MAX_ROWS],
	output nq_pkg::cell_op_t                  ops  [nq_pkg::MAX_ROWS]
);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t                           state_q;
	logic [nq_pkg::SIZE_W-1:0]        size_q;
	nq_pkg::col_t                     p_q;
	logic [nq_pkg::COUNT_W-1:0]       count_q;
	logic                             done_q;

	nq_pkg::col_t                     n_w;
	nq_pkg::cell_stat_t               act;
	logic                             out_free;
	logic                             clear_all;
	logic                             en_a;
	logic                             en_b;
	nq_pkg::col_t                     row_a;
	nq_pkg::col_t                     row_b;
	nq_pkg::cell_op_t                 op_a;
	nq_pkg::col_t                     p_d;
	logic                             done_d;
	logic                             load_w;
	logic                             rep_found_w;
	logic                             go_search;
	logic                             go_idle;
	logic [nq_pkg::PLACE_W-1:0]       place_w;

	always_comb begin
		if (size_q == '0) begin
			n_w = nq_pkg::col_t'(1);
		end else if (size_q > nq_pkg::SIZE_W'(nq_pkg::MAX_ROWS)) begin
			n_w = nq_pkg::col_t'(nq_pkg::MAX_ROWS);
		end else begin
			n_w = nq_pkg::col_t'(size_q);
		end
	end

	assign act      = stat[p_q[nq_pkg::COL_IDX_W-1:0]];
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && !cfg_we;

	always_comb begin
		place_w = '0;
		for (int r = 0; r < nq_pkg::MAX_ROWS; r++) begin
			if (nq_pkg::col_t'(r) < n_w) begin
				place_w[r*nq_pkg::PLACE_BITS +: nq_pkg::PLACE_BITS] =
					stat[r].choice[nq_pkg::PLACE_BITS-1:0];
			end
		end
	end

	always_comb begin
		clear_all   = 1'b0;
		en_a        = 1'b0;
		en_b        = 1'b0;
		row_a       = p_q;
		row_b       = p_q + nq_pkg::col_t'(1);
		op_a        = nq_pkg::OP_HOLD;
		p_d         = p_q;
		done_d      = done_q;
		load_w      = 1'b0;
		rep_found_w = 1'b0;
		go_search   = 1'b0;
		go_idle     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_we) begin
					clear_all = 1'b1;
				end else if (in_valid) begin
					go_search = 1'b1;
					clear_all = restart;
				end
			end
			ST_SEARCH: begin
				if (done_q) begin
					if (out_free) begin
						load_w  = 1'b1;
						go_idle = 1'b1;
					end
				end else if (p_q == n_w) begin
					// lift the last queen of the reported solution
					p_d   = n_w - nq_pkg::col_t'(1);
					row_a = n_w - nq_pkg::col_t'(1);
					op_a  = nq_pkg::OP_NEXT;
					en_a  = 1'b1;
				end else if (act.choice >= n_w) begin
					if (p_q == '0) begin
						if (out_free) begin
							done_d  = 1'b1;
							load_w  = 1'b1;
							go_idle = 1'b1;
						end
					end else begin
						p_d   = p_q - nq_pkg::col_t'(1);
						row_a = p_q - nq_pkg::col_t'(1);
						op_a  = nq_pkg::OP_NEXT;
						en_a  = 1'b1;
					end
				end else if (act.free) begin
					if (p_q + nq_pkg::col_t'(1) == n_w) begin
						if (out_free) begin
							op_a        = nq_pkg::OP_PLACE;
							en_a        = 1'b1;
							p_d         = n_w;
							load_w      = 1'b1;
							rep_found_w = 1'b1;
							go_idle     = 1'b1;
						end
					end else begin
						op_a = nq_pkg::OP_PLACE;
						en_a = 1'b1;
						en_b = 1'b1;
						p_d  = p_q + nq_pkg::col_t'(1);
					end
				end else begin
					op_a = nq_pkg::OP_NEXT;
					en_a = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < nq_pkg::MAX_ROWS; i++) begin
			if (clear_all) begin
				ops[i] = nq_pkg::OP_CLEAR;
			end else if (en_a && row_a == nq_pkg::col_t'(i)) begin
				ops[i] = op_a;
			end else if (en_b && row_b == nq_pkg::col_t'(i)) begin
				ops[i] = nq_pkg::OP_CLEAR;
			end else begin
				ops[i] = nq_pkg::OP_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			size_q          <= nq_pkg::BOARD_RESET;
			p_q             <= '0;
			count_q         <= '0;
			done_q          <= 1'b0;
			out_valid       <= 1'b0;
			found           <= 1'b0;
			exhausted       <= 1'b0;
			placement       <= '0;
			solution_number <= '0;
		end else begin
			if (state_q == ST_IDLE && cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (clear_all) begin
				p_q     <= '0;
				count_q <= '0;
				done_q  <= 1'b0;
			end else begin
				p_q    <= p_d;
				done_q <= done_d;
				if (rep_found_w) begin
					count_q <= count_q + nq_pkg::COUNT_W'(1);
				end
			end
			if (go_search) begin
				state_q <= ST_SEARCH;
			end else if (go_idle) begin
				state_q <= ST_IDLE;
			end
			if (load_w) begin
				out_valid <= 1'b1;
				found     <= rep_found_w;
				exhausted <= !rep_found_w;
				placement <= rep_found_w ? place_w : '0;
				solution_number <= rep_found_w ? count_q + nq_pkg::COUNT_W'(1) : count_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	`NQ_ASSERT_ALWAYS(a_row_range, p_q <= n_w, "row pointer beyond board")
	`NQ_ASSERT(a_done_row0, done_q |-> p_q == '0, "search finished away from row zero")
	`NQ_ASSERT(a_result_kind, out_valid |-> (found != exhausted),
		"result item neither a solution nor exhaustion")
	`NQ_ASSERT(a_count_step, (load_w && rep_found_w) |=>
		(solution_number == $past(count_q) + nq_pkg::COUNT_W'(1)),
		"solution number did not advance by one")

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the N-queens solution enumerator against a behavioral search that
// runs in step with the request items. Covers resume and restart, exhaustion,
// requests after exhaustion and board sizes that saturate or have no solution,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------

module tb;

	localparam int ITEM_TARGET = 950;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic                       found;
		logic                       exhausted;
		logic [nq_pkg::PLACE_W-1:0] placement;
		logic [nq_pkg::COUNT_W-1:0] number;
	} queen_result_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [nq_pkg::SIZE_W-1:0]  cfg_wdata = '0;
	logic                       in_valid  = 1'b0;
	logic                       restart   = 1'b0;
	logic                       out_ready = 1'b0;
	logic                       in_ready;
	logic                       out_valid;
	logic                       found;
	logic                       exhausted;
	logic [nq_pkg::PLACE_W-1:0] placement;
	logic [nq_pkg::COUNT_W-1:0] solution_number;

	// search state mirrored per accepted item
	logic [nq_pkg::SIZE_W-1:0]       size_setting;
	logic [3:0]                      pick_col [nq_pkg::MAX_ROWS];
	logic [3:0]                      cur_row;
	logic [nq_pkg::MAX_ROWS-1:0]     cols_used;
	logic [2*nq_pkg::MAX_ROWS-2:0]   down_used;
	logic [2*nq_pkg::MAX_ROWS-2:0]   up_used;
	logic [nq_pkg::COUNT_W-1:0]      solved_count;
	logic                            search_over;

	bit            pending_restart [$];
	queen_result_t awaited [$];
	queen_result_t head;

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  in_took;
	bit  drv_valid;
	bit  drv_restart;
	int  items_pushed;
	int  items_taken;
	int  results_seen;
	int  solutions_seen;
	int  exhausted_seen;
	int  size_writes;
	int  errors;
	int  cycles;

	n_queens_solution_enumerator_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.exhausted       (exhausted),
		.placement       (placement),
		.solution_number (solution_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_board();
		foreach (pick_col[i]) pick_col[i] = '0;
		cur_row      = '0;
		cols_used    = '0;
		down_used    = '0;
		up_used      = '0;
		solved_count = '0;
		search_over  = 1'b0;
	endfunction

	function automatic int board_edge();
		if (size_setting == 0) return 1;
		if (size_setting > nq_pkg::MAX_ROWS) return nq_pkg::MAX_ROWS;
		return int'(size_setting);
	endfunction

	function automatic void flip_queen(input int row, input int c, input int n);
		cols_used[c]           = ~cols_used[c];
		down_used[row + n - 1 - c] = ~down_used[row + n - 1 - c];
		up_used[row + c]       = ~up_used[row + c];
	endfunction

	function automatic queen_result_t next_solution(input logic from_start);
		int            n;
		int            row;
		int            c;
		int            r;
		queen_result_t res;
		n = board_edge();
		if (from_start) clear_board();
		res.found     = 1'b0;
		res.exhausted = 1'b1;
		res.placement = '0;
		res.number    = solved_count;
		if (search_over) return res;
		// lift the last queen of the previous solution
		if (cur_row >= n) begin
			cur_row = 4'(n - 1);
			flip_queen(n - 1, pick_col[n - 1], n);
			pick_col[n - 1]++;
		end
		while (cur_row < n) begin
			row = cur_row;
			c   = pick_col[row];
			if (c >= n) begin
				if (row == 0) begin
					search_over = 1'b1;
					return res;
				end
				cur_row = 4'(row - 1);
				flip_queen(row - 1, pick_col[row - 1], n);
				pick_col[row - 1]++;
			end else if (!cols_used[c] && !down_used[row + n - 1 - c] && !up_used[row + c]) begin
				flip_queen(row, c, n);
				cur_row = 4'(row + 1);
				if (row + 1 < n) pick_col[row + 1] = '0;
			end else begin
				pick_col[row]++;
			end
		end
		solved_count++;
		res.found     = 1'b1;
		res.exhausted = 1'b0;
		res.number    = solved_count;
		for (r = 0; r < n; r++) res.placement[3*r +: 3] = pick_col[r][2:0];
		return res;
	endfunction

	task automatic push_item(input bit r);
		pending_restart.push_back(r);
		items_pushed++;
	endtask

	task automatic wait_idle();
		while (items_taken != items_pushed || awaited.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_size(input logic [nq_pkg::SIZE_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		size_setting = v;
		clear_board();
		size_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(negedge clk) begin
		drv_valid   = in_valid;
		drv_restart = restart;
		if (!arst_n) begin
			drv_valid = 1'b0;
		end else begin
			if (in_took) drv_valid = 1'b0;
			in_took = 1'b0;
			if (!drv_valid && pending_restart.size() > 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				drv_valid   = 1'b1;
				drv_restart = pending_restart.pop_front();
			end
		end
		in_valid  <= drv_valid;
		restart   <= drv_restart;
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			awaited.push_back(next_solution(restart));
			in_took = 1'b1;
			items_taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (found) solutions_seen++;
			if (exhausted) exhausted_seen++;
			if (awaited.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				head = awaited.pop_front();
				if (found !== head.found) begin
					$error("found: expected %0d, got %0d", head.found, found);
					errors++;
				end
				if (exhausted !== head.exhausted) begin
					$error("exhausted: expected %0d, got %0d", head.exhausted, exhausted);
					errors++;
				end
				if (placement !== head.placement) begin
					$error("placement: expected %06h, got %06h", head.placement, placement);
					errors++;
				end
				if (solution_number !== head.number) begin
					$error("solution_number: expected %0d, got %0d",
						head.number, solution_number);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL n_queens_solution_enumerator_core");
			$finish;
		end
	end

	initial begin
		int count;
		int pct;
		size_setting  = nq_pkg::BOARD_RESET;
		clear_board();
		send_idle_pct = 11;
		recv_idle_pct = 48;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// resume straight after reset, then restart on the default board
		push_item(1'b0);
		push_item(1'b0);
		push_item(1'b0);
		push_item(1'b1);
		push_item(1'b0);
		// single square: one solution, exhaustion, request after exhaustion
		write_size(nq_pkg::SIZE_W'(1));
		push_item(1'b0);
		push_item(1'b0);
		push_item(1'b0);
		push_item(1'b1);
		// zero saturates up to one
		write_size(nq_pkg::SIZE_W'(0));
		push_item(1'b0);
		push_item(1'b0);
		// boards with no solution, then a 4x4 board
		write_size(nq_pkg::SIZE_W'(2));
		push_item(1'b0);
		push_item(1'b1);
		write_size(nq_pkg::SIZE_W'(3));
		push_item(1'b0);
		write_size(nq_pkg::SIZE_W'(4));
		push_item(1'b1);
		push_item(1'b0);
		push_item(1'b0);
		push_item(1'b0);
		// above the maximum saturates down
		write_size(nq_pkg::SIZE_W'(15));
		push_item(1'b0);
		push_item(1'b0);

		while (items_pushed < ITEM_TARGET) begin
			wait_idle();
			if (items_pushed >= 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (items_pushed >= ITEM_TARGET / 3) begin
				send_idle_pct = 48;
				recv_idle_pct = 11;
			end
			if ($urandom_range(3) != 0) write_size(nq_pkg::SIZE_W'($urandom_range(15)));
			count = $urandom_range(10, 110);
			if (count > ITEM_TARGET - items_pushed) count = ITEM_TARGET - items_pushed;
			pct   = ($urandom_range(3) == 0) ? 30 : 3;
			repeat (count) push_item($urandom_range(99) < pct);
		end
		wait_idle();

		$display("Ran %0d request items across %0d board size writes",
			items_taken, size_writes);
		$display("Got %0d results: %0d solutions, %0d exhausted answers",
			results_seen, solutions_seen, exhausted_seen);
		if (errors == 0) begin
			$display("PASS n_queens_solution_enumerator_core");
		end else begin
			$display("FAIL n_queens_solution_enumerator_core");
		end
		$finish;
	end

endmodule
